### rtl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg - shared types and constants for the takeoff detector
// Register map, beat structs and the constant-division factors.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int MS_W   = 32;
  localparam int SPD_W  = 16;
  localparam int TOD_W  = 17;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [TOD_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;

  // Register reset values
  localparam logic [SPD_W-1:0]        MIN_SPEED_RST = 16'd1000;
  localparam logic signed [SPD_W-1:0] CLIMB_RST     = 16'sd50;
  localparam logic signed [SPD_W-1:0] SINK_RST      = -16'sd50;
  localparam logic [SPD_W-1:0]        TIMEOUT_RST   = 16'd1200;
  localparam logic [SPD_W-1:0]        HOLD_RST      = 16'd2000;

  // Reciprocal multipliers, exact for elapsed < one day
  localparam int                  QMIN_W        = 11;
  localparam int                  P60_W         = 35;
  localparam logic [P60_W-1:0]    DIV60_MUL     = 35'd139811;
  localparam int                  DIV60_SHIFT   = 23;
  localparam int                  P3600_W       = 33;
  localparam logic [P3600_W-1:0]  DIV3600_MUL   = 33'd37283;
  localparam int                  DIV3600_SHIFT = 27;

  typedef enum logic [2:0] {
    REG_MIN_SPEED = 3'd0,
    REG_CLIMB     = 3'd1,
    REG_SINK      = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_HOLD      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SPD_W-1:0]        min_speed;
    logic signed [SPD_W-1:0] climb;
    logic signed [SPD_W-1:0] sink;
    logic [SPD_W-1:0]        timeout_ms;
    logic [SPD_W-1:0]        hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [MS_W-1:0]         now_ms;
    logic                    gps_fixed;
    logic [MS_W-1:0]         position_time_ms;
    logic [MS_W-1:0]         speed_time_ms;
    logic [SPD_W-1:0]        ground_speed;
    logic signed [SPD_W-1:0] vertical_speed;
    logic [HOUR_W-1:0]       utc_hour;
    logic [MIN_W-1:0]        utc_minute;
    logic [SEC_W-1:0]        utc_second;
    logic                    manual_start;
  } sample_t;

  typedef struct packed {
    logic             in_flight;
    logic             takeoff_now;
    logic [TOD_W-1:0] elapsed;
  } flight_t;

  typedef struct packed {
    logic              in_flight;
    logic              takeoff_now;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } hms_t;

endpackage

`default_nettype wire

### rtl/tkd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tkd_cfg_regs - configuration register file
// APB-style write/read of the five threshold and timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tkd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tkd_pkg::DATA_W-1:0]  pwdata,
  output logic      [tkd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output tkd_pkg::cfg_t                    cfg
);

  logic              wr_en;
  tkd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = tkd_pkg::reg_idx_t'(paddr[tkd_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_speed  <= tkd_pkg::MIN_SPEED_RST;
      cfg.climb      <= tkd_pkg::CLIMB_RST;
      cfg.sink       <= tkd_pkg::SINK_RST;
      cfg.timeout_ms <= tkd_pkg::TIMEOUT_RST;
      cfg.hold_ms    <= tkd_pkg::HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        tkd_pkg::REG_MIN_SPEED: cfg.min_speed  <= pwdata[tkd_pkg::SPD_W-1:0];
        tkd_pkg::REG_CLIMB:     cfg.climb      <= pwdata[tkd_pkg::SPD_W-1:0];
        tkd_pkg::REG_SINK:      cfg.sink       <= pwdata[tkd_pkg::SPD_W-1:0];
        tkd_pkg::REG_TIMEOUT:   cfg.timeout_ms <= pwdata[tkd_pkg::SPD_W-1:0];
        tkd_pkg::REG_HOLD:      cfg.hold_ms    <= pwdata[tkd_pkg::SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign-extended
  always_comb begin
    unique case (idx)
      tkd_pkg::REG_MIN_SPEED: prdata = {16'd0, cfg.min_speed};
      tkd_pkg::REG_CLIMB:     prdata = {{16{cfg.climb[15]}}, cfg.climb};
      tkd_pkg::REG_SINK:      prdata = {{16{cfg.sink[15]}}, cfg.sink};
      tkd_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_ms};
      tkd_pkg::REG_HOLD:      prdata = {16'd0, cfg.hold_ms};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tkd_detect.sv
// ----------------------------------------------------------------------------
// tkd_detect - takeoff decision and elapsed-seconds stage
// Input register, hold timer / start latch, elapsed time of day.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_detect #(
  parameter int TIME_BITS = tkd_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  tkd_pkg::cfg_t         cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  tkd_pkg::sample_t      sample,
  output logic                  det_valid,
  input  wire logic             det_ready,
  output tkd_pkg::flight_t      det_beat
);

  localparam int TOD_W = tkd_pkg::TOD_W;

  // input register
  logic                              v0;
  logic [TIME_BITS-1:0]              s0_now;
  logic [TIME_BITS-1:0]              s0_pos;
  logic [TIME_BITS-1:0]              s0_spd;
  logic                              s0_fixed;
  logic                              s0_manual;
  logic [tkd_pkg::SPD_W-1:0]         s0_gspeed;
  logic signed [tkd_pkg::SPD_W-1:0]  s0_vspeed;
  logic [TOD_W-1:0]                  s0_tod;
  logic [TOD_W-1:0]                  tod_in;

  // detector state
  logic                 started, started_next;
  logic                 armed, armed_next;
  logic [TIME_BITS-1:0] begin_ms, begin_ms_next;
  logic [TOD_W-1:0]     start_tod, start_tod_next;

  logic                 s1_free;
  logic                 s0_move;
  logic [TIME_BITS-1:0] pos_age, spd_age, hold_age;
  logic [TIME_BITS-1:0] timeout_ext, hold_ext;
  logic                 fresh, qualify, takeoff;
  logic [TOD_W:0]       diff, wrap_up, wrap_down;
  logic [TOD_W-1:0]     elapsed;
  tkd_pkg::flight_t     flight_next;

  assign s1_free  = !det_valid || det_ready;
  assign s0_move  = v0 && s1_free;
  assign in_ready = !v0 || s1_free;

  // time of day folded before the register
  assign tod_in = TOD_W'(sample.utc_hour) * tkd_pkg::SECS_PER_HOUR
                + TOD_W'(sample.utc_minute) * tkd_pkg::SECS_PER_MIN
                + TOD_W'(sample.utc_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_now    <= sample.now_ms[TIME_BITS-1:0];
      s0_pos    <= sample.position_time_ms[TIME_BITS-1:0];
      s0_spd    <= sample.speed_time_ms[TIME_BITS-1:0];
      s0_fixed  <= sample.gps_fixed;
      s0_manual <= sample.manual_start;
      s0_gspeed <= sample.ground_speed;
      s0_vspeed <= sample.vertical_speed;
      s0_tod    <= tod_in;
    end
  end

  // modular ages in TIME_BITS
  assign pos_age     = s0_now - s0_pos;
  assign spd_age     = s0_now - s0_spd;
  assign hold_age    = s0_now - begin_ms;
  assign timeout_ext = TIME_BITS'(cfg.timeout_ms);
  assign hold_ext    = TIME_BITS'(cfg.hold_ms);

  assign fresh   = s0_fixed && (pos_age < timeout_ext) && (spd_age < timeout_ext);
  assign qualify = (s0_gspeed >= cfg.min_speed) &&
                   (($signed(s0_vspeed) >= $signed(cfg.climb)) ||
                    ($signed(s0_vspeed) <= $signed(cfg.sink)));
  assign takeoff = !started && fresh &&
                   (s0_manual || (qualify && armed && (hold_age > hold_ext)));

  always_comb begin
    armed_next    = armed;
    begin_ms_next = begin_ms;
    if (!started) begin
      if (fresh) begin
        if (!s0_manual && qualify && !armed) begin
          armed_next    = 1'b1;
          begin_ms_next = s0_now;
        end
      end else begin
        armed_next = 1'b0;
      end
    end
  end

  assign started_next   = started || takeoff;
  assign start_tod_next = takeoff ? s0_tod : start_tod;

  // elapsed seconds; a takeoff sample reads zero since started is still low
  assign diff      = {1'b0, s0_tod} - {1'b0, start_tod};
  assign wrap_up   = diff + {1'b0, tkd_pkg::SECS_PER_DAY};
  assign wrap_down = diff - {1'b0, tkd_pkg::SECS_PER_DAY};

  always_comb begin
    if (!started) begin
      elapsed = '0;
    end else if (diff[TOD_W]) begin
      elapsed = wrap_up[TOD_W-1:0];
    end else if (diff[TOD_W-1:0] >= tkd_pkg::SECS_PER_DAY) begin
      elapsed = wrap_down[TOD_W-1:0];
    end else begin
      elapsed = diff[TOD_W-1:0];
    end
  end

  always_comb begin
    flight_next.in_flight   = started_next;
    flight_next.takeoff_now = takeoff;
    flight_next.elapsed     = elapsed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      armed     <= 1'b0;
      begin_ms  <= '0;
      start_tod <= '0;
    end else if (s0_move) begin
      started   <= started_next;
      armed     <= armed_next;
      begin_ms  <= begin_ms_next;
      start_tod <= start_tod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_valid <= 1'b0;
    end else if (s1_free) begin
      det_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move) begin
      det_beat <= flight_next;
    end
  end

  a_takeoff_latches: assert property (@(posedge clk) disable iff (rst)
    s0_move && takeoff |=> started)
    else $error("start flag not set after takeoff");

  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("start flag dropped");

  a_stale_disarms: assert property (@(posedge clk) disable iff (rst)
    s0_move && !started && !fresh |=> !armed)
    else $error("hold timer armed across stale data");

  a_takeoff_beat: assert property (@(posedge clk) disable iff (rst)
    det_valid && det_beat.takeoff_now |-> det_beat.in_flight && det_beat.elapsed == '0)
    else $error("takeoff beat inconsistent");

  a_elapsed_range: assert property (@(posedge clk) disable iff (rst)
    det_valid |-> det_beat.elapsed < tkd_pkg::SECS_PER_DAY)
    else $error("elapsed seconds exceed one day");

endmodule

`default_nettype wire

### rtl/tkd_hms.sv
// ----------------------------------------------------------------------------
// tkd_hms - elapsed seconds to hours, minutes, seconds
// Reciprocal multiply stage, then remainder stage into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_hms (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         det_valid,
  output logic              det_ready,
  input  tkd_pkg::flight_t  det_beat,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tkd_pkg::hms_t     out_beat
);

  localparam int TOD_W  = tkd_pkg::TOD_W;
  localparam int QMIN_W = tkd_pkg::QMIN_W;

  logic                         va;
  logic                         a_in_flight, a_takeoff;
  logic [TOD_W-1:0]             a_secs;
  logic [QMIN_W-1:0]            a_mins;   // whole minutes
  logic [tkd_pkg::HOUR_W-1:0]   a_hours;

  logic                         out_free, a_free;
  logic [tkd_pkg::P60_W-1:0]    p60;
  logic [tkd_pkg::P3600_W-1:0]  p3600;
  logic [QMIN_W-1:0]            min_rem;
  logic [TOD_W-1:0]             sec_rem;
  tkd_pkg::hms_t                hms_next;

  assign out_free  = !out_valid || out_ready;
  assign a_free    = !va || out_free;
  assign det_ready = a_free;

  assign p60   = tkd_pkg::P60_W'(det_beat.elapsed) * tkd_pkg::DIV60_MUL;
  assign p3600 = tkd_pkg::P3600_W'(det_beat.elapsed) * tkd_pkg::DIV3600_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (a_free) begin
      va <= det_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (det_valid && a_free) begin
      a_in_flight <= det_beat.in_flight;
      a_takeoff   <= det_beat.takeoff_now;
      a_secs      <= det_beat.elapsed;
      a_mins      <= p60[tkd_pkg::DIV60_SHIFT +: QMIN_W];
      a_hours     <= p3600[tkd_pkg::DIV3600_SHIFT +: tkd_pkg::HOUR_W];
    end
  end

  assign min_rem = a_mins - QMIN_W'(a_hours) * QMIN_W'(tkd_pkg::SECS_PER_MIN);
  assign sec_rem = a_secs - TOD_W'(a_mins) * tkd_pkg::SECS_PER_MIN;

  always_comb begin
    hms_next.in_flight   = a_in_flight;
    hms_next.takeoff_now = a_takeoff;
    hms_next.hours       = a_hours;
    hms_next.minutes     = min_rem[tkd_pkg::MIN_W-1:0];
    hms_next.seconds     = sec_rem[tkd_pkg::SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va && out_free) begin
      out_beat <= hms_next;
    end
  end

endmodule

`default_nettype wire

### rtl/takeoff_detector.sv
// Throughput: one sample per cycle, set by the four-register pipeline
// (input, decision, divide, result); every stage holds under back-pressure.
// Reset (rst, synchronous, active high): clears the start latch, hold timer,
// stored start time and all valid bits; registers return to their defaults.
// ----------------------------------------------------------------------------
// takeoff_detector - GPS takeoff detector with flight clock
// Decides takeoff from fresh GPS speed and vario data or a manual start,
// latches start time of day and reports elapsed flight h:m:s every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module takeoff_detector #(
  // width of the wrapping millisecond counter used for ages
  parameter int TIME_BITS = tkd_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,

  // sample channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tkd_pkg::MS_W-1:0]           now_ms,
  input  wire logic                               gps_fixed,
  input  wire logic [tkd_pkg::MS_W-1:0]           position_time_ms,
  input  wire logic [tkd_pkg::MS_W-1:0]           speed_time_ms,
  input  wire logic [tkd_pkg::SPD_W-1:0]          ground_speed,
  input  wire logic signed [tkd_pkg::SPD_W-1:0]   vertical_speed,
  input  wire logic [tkd_pkg::HOUR_W-1:0]         utc_hour,
  input  wire logic [tkd_pkg::MIN_W-1:0]          utc_minute,
  input  wire logic [tkd_pkg::SEC_W-1:0]          utc_second,
  input  wire logic                               manual_start,

  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    in_flight,
  output logic                                    takeoff_now,
  output logic [tkd_pkg::HOUR_W-1:0]              elapsed_hours,
  output logic [tkd_pkg::MIN_W-1:0]               elapsed_minutes,
  output logic [tkd_pkg::SEC_W-1:0]               elapsed_seconds,

  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tkd_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [tkd_pkg::DATA_W-1:0]         pwdata,
  output logic      [tkd_pkg::DATA_W-1:0]         prdata,
  output logic                                    pready
);

  tkd_pkg::cfg_t    cfg;
  tkd_pkg::sample_t sample;
  tkd_pkg::flight_t det_beat;
  tkd_pkg::hms_t    out_beat;
  logic             det_valid;
  logic             det_ready;

  // pack the sample beat
  always_comb begin
    sample.now_ms           = now_ms;
    sample.gps_fixed        = gps_fixed;
    sample.position_time_ms = position_time_ms;
    sample.speed_time_ms    = speed_time_ms;
    sample.ground_speed     = ground_speed;
    sample.vertical_speed   = vertical_speed;
    sample.utc_hour         = utc_hour;
    sample.utc_minute       = utc_minute;
    sample.utc_second       = utc_second;
    sample.manual_start     = manual_start;
  end

  // thresholds and timing; to be written only while the pipeline is empty, a rule left to the user
  tkd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // freshness, hold timer, start latch and elapsed seconds
  tkd_detect #(
    .TIME_BITS (TIME_BITS)
  ) u_detect (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .det_valid (det_valid),
    .det_ready (det_ready),
    .det_beat  (det_beat)
  );

  // seconds to h:m:s by reciprocal multiply, then remainders
  tkd_hms u_hms (
    .clk       (clk),
    .rst       (rst),
    .det_valid (det_valid),
    .det_ready (det_ready),
    .det_beat  (det_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  assign in_flight       = out_beat.in_flight;
  assign takeoff_now     = out_beat.takeoff_now;
  assign elapsed_hours   = out_beat.hours;
  assign elapsed_minutes = out_beat.minutes;
  assign elapsed_seconds = out_beat.seconds;

endmodule

`default_nettype wire
